// ===== rtl/assert_macros.svh =====
// assertion helpers, clocked and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/tcse_pkg.sv =====
package tcse_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 11;

    localparam logic [2*BYTE_W-1:0] BLANK_CELL   = 16'h0720;
    localparam logic [BYTE_W-1:0]   NEWLINE_BYTE = 8'h0A;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic do_put;
        logic do_clear;
        logic do_read;
        logic sweep_start;
        logic sweep_clear;
        logic out_load;
        logic out_sel_read;
        logic out_scrolled;
    } t_ctl;

    typedef struct packed {
        logic wrap;
        logic sweep_busy;
        logic sweep_done;
    } t_sts;

endpackage

// ===== rtl/tcse_ctrl.sv =====
module tcse_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  tcse_pkg::t_cmd  i_cmd,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    input  tcse_pkg::t_sts  i_sts,
    output tcse_pkg::t_ctl  o_ctl
);
    import tcse_pkg::*;

    typedef enum logic [3:0] {
        S_BOOT  = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SWEEP = 4'b0100,
        S_READ  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_emit, n_emit;
    logic   r_scrl, n_scrl;
    logic   accept;
    t_ctl   ctl;

    assign o_stall = !((r_state == S_IDLE) && (!r_out_valid || !i_stall));
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_ctl   = ctl;

    always_comb begin
        n_state = r_state;
        n_emit  = r_emit;
        n_scrl  = r_scrl;
        ctl     = '0;
        unique case (r_state)
            S_BOOT: begin
                ctl.sweep_start = 1'b1;
                ctl.sweep_clear = 1'b1;
                n_emit          = 1'b0;
                n_scrl          = 1'b0;
                n_state         = S_SWEEP;
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd)
                        CMD_PUT: begin
                            ctl.do_put = 1'b1;
                            if (i_sts.wrap) begin
                                ctl.sweep_start = 1'b1;
                                n_emit          = 1'b1;
                                n_scrl          = 1'b1;
                                n_state         = S_SWEEP;
                            end else begin
                                ctl.out_load = 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            ctl.do_clear    = 1'b1;
                            ctl.sweep_start = 1'b1;
                            ctl.sweep_clear = 1'b1;
                            n_emit          = 1'b1;
                            n_scrl          = 1'b0;
                            n_state         = S_SWEEP;
                        end
                        CMD_READ: begin
                            ctl.do_read = 1'b1;
                            n_state     = S_READ;
                        end
                        CMD_NONE: begin
                            ctl.out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                if (i_sts.sweep_done) begin
                    ctl.out_load     = r_emit;
                    ctl.out_scrolled = r_scrl;
                    n_state          = S_IDLE;
                end
            end
            S_READ: begin
                ctl.out_load     = 1'b1;
                ctl.out_sel_read = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_BOOT;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (ctl.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_BOOT;
            r_out_valid <= 1'b0;
            r_emit      <= 1'b0;
            r_scrl      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_emit      <= n_emit;
            r_scrl      <= n_scrl;
        end
    end

endmodule

// ===== rtl/tcse_dp.sv =====
module tcse_dp #(
    parameter int COLUMNS = tcse_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcse_pkg::ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tcse_pkg::BYTE_W-1:0]   i_ch,
    input  logic [tcse_pkg::BYTE_W-1:0]   i_attr,
    input  logic [tcse_pkg::IDX_W-1:0]    i_cell_index,
    input  tcse_pkg::t_ctl                i_ctl,
    output tcse_pkg::t_sts                o_sts,
    output logic [tcse_pkg::IDX_W-1:0]    o_cursor_cell,
    output logic [tcse_pkg::BYTE_W-1:0]   o_read_char,
    output logic [tcse_pkg::BYTE_W-1:0]   o_read_attr,
    output logic                          o_scrolled
);
    import tcse_pkg::*;

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int AW        = $clog2(CELLS);
    localparam int COLW      = $clog2(COLUMNS);
    localparam int RW        = $clog2(ROWS);
    localparam int LAST_CELL = CELLS - 1;
    localparam int COPY_END  = CELLS - COLUMNS;
    localparam int BOTTOM    = (ROWS - 1) * COLUMNS;
    localparam int CMP_W     = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam int CELL_W    = 2 * BYTE_W;

    logic [CELL_W-1:0] mem [CELLS];

    logic [AW-1:0]     r_cursor, n_cursor;
    logic [COLW-1:0]   r_col, n_col;
    logic [RW-1:0]     r_row, n_row;

    logic              r_sw_act;
    logic              r_sw_copy;
    logic [AW-1:0]     r_sw_idx;
    logic              r_p_act;
    logic              r_p_copy;
    logic [AW-1:0]     r_p_idx;

    logic [CELL_W-1:0] r_rd_data;
    logic              r_rd_ok;

    logic [IDX_W-1:0]  r_o_cursor;
    logic [BYTE_W-1:0] r_o_char;
    logic [BYTE_W-1:0] r_o_attr;
    logic              r_o_scrolled;

    logic              newline;
    logic              last_col;
    logic              last_row;
    logic              wrap;
    logic              addr_ok;
    logic              we;
    logic [AW-1:0]     wa;
    logic [CELL_W-1:0] wd;
    logic [AW-1:0]     ra;

    assign newline  = (i_ch == NEWLINE_BYTE);
    assign last_col = (r_col == COLW'(COLUMNS - 1));
    assign last_row = (r_row == RW'(ROWS - 1));
    assign wrap     = last_row && (newline || last_col);
    assign addr_ok  = (CMP_W'(i_cell_index) < CMP_W'(CELLS));

    assign o_sts.wrap       = wrap;
    assign o_sts.sweep_busy = r_sw_act || r_p_act;
    assign o_sts.sweep_done = r_p_act && (r_p_idx == AW'(LAST_CELL));

    // cursor, row and column track together
    always_comb begin
        n_cursor = r_cursor;
        n_col    = r_col;
        n_row    = r_row;
        if (i_ctl.do_put) begin
            if (wrap) begin
                n_cursor = AW'(BOTTOM);
                n_col    = '0;
                n_row    = RW'(ROWS - 1);
            end else if (newline) begin
                n_cursor = r_cursor + AW'(COLUMNS) - AW'(r_col);
                n_col    = '0;
                n_row    = r_row + RW'(1);
            end else if (last_col) begin
                n_cursor = r_cursor + AW'(1);
                n_col    = '0;
                n_row    = r_row + RW'(1);
            end else begin
                n_cursor = r_cursor + AW'(1);
                n_col    = r_col + COLW'(1);
            end
        end else if (i_ctl.do_clear) begin
            n_cursor = '0;
            n_col    = '0;
            n_row    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_cursor <= n_cursor;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

    // sweep: read the cell a row down, write it (or blank) in the following cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_act  <= 1'b0;
            r_sw_copy <= 1'b0;
            r_sw_idx  <= '0;
            r_p_act   <= 1'b0;
            r_p_copy  <= 1'b0;
            r_p_idx   <= '0;
        end else begin
            if (i_ctl.sweep_start) begin
                r_sw_act  <= 1'b1;
                r_sw_copy <= !i_ctl.sweep_clear;
                r_sw_idx  <= '0;
            end else if (r_sw_act) begin
                r_sw_idx <= r_sw_idx + AW'(1);
                if (r_sw_idx == AW'(LAST_CELL)) begin
                    r_sw_act <= 1'b0;
                end
            end
            r_p_act  <= r_sw_act;
            r_p_idx  <= r_sw_idx;
            r_p_copy <= r_sw_copy && (r_sw_idx < AW'(COPY_END));
        end
    end

    assign we = r_p_act || (i_ctl.do_put && !newline);
    assign wa = r_p_act ? r_p_idx : r_cursor;
    assign wd = r_p_act ? (r_p_copy ? r_rd_data : BLANK_CELL) : {i_attr, i_ch};
    assign ra = r_sw_act ? (r_sw_idx + AW'(COLUMNS)) : AW'(i_cell_index);

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd_data <= mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.do_read) begin
            r_rd_ok <= addr_ok;
        end
        if (i_ctl.out_load) begin
            r_o_cursor   <= IDX_W'(n_cursor);
            r_o_scrolled <= i_ctl.out_scrolled;
            if (i_ctl.out_sel_read && r_rd_ok) begin
                r_o_char <= r_rd_data[BYTE_W-1:0];
                r_o_attr <= r_rd_data[CELL_W-1:BYTE_W];
            end else begin
                r_o_char <= '0;
                r_o_attr <= '0;
            end
        end
    end

    assign o_cursor_cell = r_o_cursor;
    assign o_read_char   = r_o_char;
    assign o_read_attr   = r_o_attr;
    assign o_scrolled    = r_o_scrolled;

endmodule

// ===== rtl/text_console_scroll_engine.sv =====
// channel | valid   | stall   | word
// in      | i_valid | o_stall | i_cmd, i_ch, i_attr, i_cell_index
// out     | o_valid | i_stall | o_cursor_cell, o_read_char, o_read_attr, o_scrolled
//
// put (no scroll), unused command: loaded on accept; read: after the registered read
// scroll and clear: one cell per cycle through the single write port
// after reset the screen store is blanked, no word accepted meanwhile
// one word in flight; a new word is taken once the result register is free or being taken
`include "assert_macros.svh"

module text_console_scroll_engine #(
    parameter int COLUMNS = tcse_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcse_pkg::ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [tcse_pkg::CMD_W-1:0]    i_cmd,
    input  logic [tcse_pkg::BYTE_W-1:0]   i_ch,
    input  logic [tcse_pkg::BYTE_W-1:0]   i_attr,
    input  logic [tcse_pkg::IDX_W-1:0]    i_cell_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [tcse_pkg::IDX_W-1:0]    o_cursor_cell,
    output logic [tcse_pkg::BYTE_W-1:0]   o_read_char,
    output logic [tcse_pkg::BYTE_W-1:0]   o_read_attr,
    output logic                          o_scrolled
);
    import tcse_pkg::*;

    t_ctl ctl;
    t_sts sts;
    logic in_accept;

    assign in_accept = i_valid && !o_stall;

    tcse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (t_cmd'(i_cmd)),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    tcse_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ch          (i_ch),
        .i_attr        (i_attr),
        .i_cell_index  (i_cell_index),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .o_cursor_cell (o_cursor_cell),
        .o_read_char   (o_read_char),
        .o_read_attr   (o_read_attr),
        .o_scrolled    (o_scrolled)
    );

    `ASSERT_NEVER(a_no_accept_in_sweep, i_clk, i_rst_n, in_accept && sts.sweep_busy, "word accepted during sweep")
    `ASSERT_NEVER(a_no_result_overrun, i_clk, i_rst_n, ctl.out_load && o_valid && i_stall, "result overwritten while stalled")
    `ASSERT_CLK(a_sweep_starts, i_clk, i_rst_n, ctl.sweep_start |=> sts.sweep_busy, "sweep did not start")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import tcse_pkg::*;

    localparam int COLS        = COLUMNS_DEF;
    localparam int LINES       = ROWS_DEF;
    localparam int CELLS       = COLS * LINES;
    localparam int CW          = $clog2(CELLS);
    localparam int QUIET_LIMIT = 8 * (CELLS + 2) + 1000;

    typedef struct packed {
        logic [IDX_W-1:0]  cursor;
        logic [BYTE_W-1:0] rch;
        logic [BYTE_W-1:0] rattr;
        logic              scrolled;
    } t_view;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic [CMD_W-1:0]  i_cmd        = '0;
    logic [BYTE_W-1:0] i_ch         = '0;
    logic [BYTE_W-1:0] i_attr       = '0;
    logic [IDX_W-1:0]  i_cell_index = '0;
    logic              i_stall      = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [IDX_W-1:0]  o_cursor_cell;
    logic [BYTE_W-1:0] o_read_char;
    logic [BYTE_W-1:0] o_read_attr;
    logic              o_scrolled;

    // console shadow and the views it predicts
    logic [2*BYTE_W-1:0] shadow_screen [CELLS];
    int                  shadow_cursor;
    t_view               views_due [$];

    int errors       = 0;
    int words_sent   = 0;
    int views_seen   = 0;
    int n_reads      = 0;
    int n_far_reads  = 0;
    int n_scrolls    = 0;
    int n_clears     = 0;
    int gap_pct      = 0;
    int stall_pct    = 0;
    int hold_request = 0;

    text_console_scroll_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_ch         (i_ch),
        .i_attr       (i_attr),
        .i_cell_index (i_cell_index),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cursor_cell(o_cursor_cell),
        .o_read_char  (o_read_char),
        .o_read_attr  (o_read_attr),
        .o_scrolled   (o_scrolled)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int pick_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(15, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++)
            shadow_screen[CW'(i)] = BLANK_CELL;
    endfunction

    function automatic t_view advance_console(t_cmd cmd, logic [BYTE_W-1:0] ch,
                                              logic [BYTE_W-1:0] attr,
                                              logic [IDX_W-1:0] idx);
        t_view v;
        v = '0;
        if (shadow_cursor >= CELLS)
            shadow_cursor = 0;
        case (cmd)
            CMD_PUT: begin
                if (ch == NEWLINE_BYTE) begin
                    shadow_cursor = (shadow_cursor / COLS + 1) * COLS;
                end else begin
                    shadow_screen[CW'(shadow_cursor)] = {attr, ch};
                    shadow_cursor++;
                end
                if (shadow_cursor >= CELLS) begin
                    for (int i = 0; i < CELLS - COLS; i++)
                        shadow_screen[CW'(i)] = shadow_screen[CW'(i + COLS)];
                    for (int i = CELLS - COLS; i < CELLS; i++)
                        shadow_screen[CW'(i)] = BLANK_CELL;
                    shadow_cursor -= COLS;
                    v.scrolled = 1'b1;
                end
            end
            CMD_CLEAR: begin
                blank_screen();
                shadow_cursor = 0;
            end
            CMD_READ: begin
                if (idx < CELLS)
                    {v.rattr, v.rch} = shadow_screen[CW'(idx)];
            end
            default: ;
        endcase
        v.cursor = shadow_cursor[IDX_W-1:0];
        return v;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on word %0d: %s got %0d expected %0d", views_seen, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_view got;
        t_view want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_cursor_cell, o_read_char, o_read_attr, o_scrolled};
            if (views_due.size() == 0) begin
                report_mismatch("unexpected word, cursor", int'(got.cursor), 0);
            end else begin
                want = views_due.pop_front();
                if (got.cursor !== want.cursor)
                    report_mismatch("cursor_cell", int'(got.cursor), int'(want.cursor));
                if (got.rch !== want.rch)
                    report_mismatch("read_char", int'(got.rch), int'(want.rch));
                if (got.rattr !== want.rattr)
                    report_mismatch("read_attr", int'(got.rattr), int'(want.rattr));
                if (got.scrolled !== want.scrolled)
                    report_mismatch("scrolled", int'(got.scrolled), int'(want.scrolled));
            end
            views_seen++;
        end
        if (i_rst_n && i_valid && !o_stall) begin
            want = advance_console(t_cmd'(i_cmd), i_ch, i_attr, i_cell_index);
            views_due.push_back(want);
            if (t_cmd'(i_cmd) == CMD_READ) begin
                n_reads++;
                if (i_cell_index >= CELLS)
                    n_far_reads++;
            end
            if (t_cmd'(i_cmd) == CMD_CLEAR)
                n_clears++;
            if (want.scrolled)
                n_scrolls++;
        end
    end

    initial begin : sink
        int run;
        run = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                i_stall <= 1'b1;
                hold_request--;
            end else if (run > 0) begin
                i_stall <= 1'b1;
                run--;
            end else if ($urandom_range(1, 100) <= stall_pct) begin
                run = pick_len() - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout after %0d quiet cycles", quiet);
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_word(t_cmd cmd, logic [BYTE_W-1:0] ch, logic [BYTE_W-1:0] attr,
                             logic [IDX_W-1:0] idx);
        int gap;
        gap = ($urandom_range(1, 100) <= gap_pct) ? pick_len() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_ch         <= ch;
        i_attr       <= attr;
        i_cell_index <= idx;
        do @(posedge i_clk); while (o_stall);
        if (cmd != CMD_NONE)
            words_sent++;
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (views_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic read_cell(int idx);
        send_word(CMD_READ, BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                  IDX_W'(idx));
    endtask

    task automatic test_reset_contents();
        read_cell(0);
        read_cell(CELLS - 1);
        read_cell(CELLS);
        read_cell(2047);
        send_word(CMD_NONE, 8'hFF, 8'hFF, 11'h7FF);
        send_word(CMD_NONE, 8'h00, 8'h00, 11'h000);
        wait_drain();
    endtask

    task automatic test_put_extremes();
        send_word(CMD_PUT, 8'hFF, 8'hFF, 11'h7FF);
        send_word(CMD_PUT, 8'h00, 8'h00, 11'h000);
        send_word(CMD_PUT, 8'h41, 8'h0F, 11'h555);
        send_word(CMD_PUT, NEWLINE_BYTE, 8'hFF, 11'h2AA);
        send_word(CMD_PUT, 8'h42, 8'h0E, 11'h000);
        read_cell(0);
        read_cell(1);
        read_cell(2);
        read_cell(3);
        read_cell(COLS);
        wait_drain();
    endtask

    task automatic test_clear();
        send_word(CMD_PUT, 8'h5A, 8'hA5, 11'h000);
        send_word(CMD_CLEAR, 8'hFF, 8'hFF, 11'h7FF);
        read_cell(0);
        read_cell(COLS);
        wait_drain();
    endtask

    // walk to the bottom row with newlines, then scroll with one more
    task automatic test_bottom_newline();
        send_word(CMD_CLEAR, 8'h00, 8'h00, 11'h000);
        send_word(CMD_PUT, 8'h41, 8'h1E, 11'h000);
        for (int r = 0; r < LINES - 1; r++)
            send_word(CMD_PUT, NEWLINE_BYTE, BYTE_W'($urandom_range(0, 255)),
                      IDX_W'($urandom_range(0, 2047)));
        send_word(CMD_PUT, 8'h5A, 8'h0F, 11'h000);
        send_word(CMD_PUT, NEWLINE_BYTE, 8'h00, 11'h000);
        read_cell(CELLS - 2 * COLS);
        read_cell(CELLS - COLS);
        read_cell(0);
        wait_drain();
    endtask

    task automatic test_backpressure();
        gap_pct      = 0;
        stall_pct    = 0;
        hold_request = 300;
        for (int k = 0; k < 12; k++) begin
            if (k % 3 == 2)
                read_cell($urandom_range(0, CELLS - 1));
            else
                send_word(CMD_PUT, BYTE_W'(8'h30 + k), BYTE_W'($urandom_range(0, 255)),
                          11'h000);
        end
        wait_drain();
    endtask

    task automatic test_random_text(int words);
        int target;
        int pick;
        int len;
        int idx;
        logic [BYTE_W-1:0] ch;
        target = words_sent + words;
        while (words_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(70, 170)
                                                  : $urandom_range(0, 30);
                for (int c = 0; c < len; c++) begin
                    ch = BYTE_W'($urandom_range(0, 255));
                    if (ch == NEWLINE_BYTE)
                        ch = 8'h20;
                    send_word(CMD_PUT, ch, BYTE_W'($urandom_range(0, 255)),
                              IDX_W'($urandom_range(0, 2047)));
                end
                if ($urandom_range(0, 99) < 85)
                    send_word(CMD_PUT, NEWLINE_BYTE, BYTE_W'($urandom_range(0, 255)),
                              IDX_W'($urandom_range(0, 2047)));
            end else if (pick < 85) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    idx = $urandom_range(CELLS, 2047);
                end else if (pick < 5) begin
                    idx = $urandom_range(0, 90);
                    idx = shadow_cursor - idx;
                    if (idx < 0)
                        idx = 0;
                end else begin
                    idx = $urandom_range(0, CELLS - 1);
                end
                read_cell(idx);
            end else if (pick < 88) begin
                send_word(CMD_CLEAR, BYTE_W'($urandom_range(0, 255)),
                          BYTE_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 2047)));
            end else if (pick < 93) begin
                send_word(CMD_NONE, BYTE_W'($urandom_range(0, 255)),
                          BYTE_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 2047)));
            end else begin
                send_word(t_cmd'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
                          BYTE_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 2047)));
            end
        end
        wait_drain();
    endtask

    initial begin
        blank_screen();
        shadow_cursor = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        gap_pct   = 20;
        stall_pct = 20;
        test_reset_contents();
        test_put_extremes();
        test_clear();
        test_bottom_newline();
        test_backpressure();

        gap_pct   = 0;
        stall_pct = 0;
        test_random_text(150);
        gap_pct   = 25;
        stall_pct = 25;
        test_random_text(500);
        gap_pct   = 0;
        stall_pct = 40;
        test_random_text(150);

        repeat (CELLS + 10) @(posedge i_clk);
        $display("run covered %0d words and %0d results: %0d reads (%0d out of range)",
                 words_sent, views_seen, n_reads, n_far_reads);
        $display("screen scrolled %0d times and was cleared %0d times, %0d mismatches",
                 n_scrolls, n_clears, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tcse_pkg.sv
rtl/tcse_ctrl.sv
rtl/tcse_dp.sv
rtl/text_console_scroll_engine.sv
test/tb_top.sv
